@@ sv/pea_pkg.sv @@
// ----------------------------------------------------------------------------
// Page extent allocator package
// Item types and constants shared by the allocator modules.
// ----------------------------------------------------------------------------
package pea_pkg;

  localparam logic OP_RESERVE = 1'b0;
  localparam logic OP_RELEASE = 1'b1;

  localparam logic STATUS_DONE = 1'b0;
  localparam logic STATUS_FULL = 1'b1;

  localparam logic [63:0] HEAP_BASE_RESET = 64'd4096;

  typedef struct packed {
    logic        op;
    logic [63:0] address;
    logic [31:0] pages;
  } req_t;

  typedef struct packed {
    logic [63:0] result_address;
    logic        status;
  } rsp_t;

endpackage

@@ sv/pea_ram.sv @@
// ----------------------------------------------------------------------------
// Generic RAM
// Single write port, single read port, registered read data.
// ----------------------------------------------------------------------------
module pea_ram #(
  parameter int WIDTH = 96,
  parameter int DEPTH = 32
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

@@ sv/page_extent_allocator_core.sv @@
// ----------------------------------------------------------------------------
// Page extent allocator core
// Worst-fit free list of page extents kept in one synchronous RAM.
// ----------------------------------------------------------------------------
// A reserve trims an extent, removes it, or takes from the top. A reserve
// scan step passes through S_RRD and S_RCHK. A release scan step passes
// through S_LRD, S_LSPN and S_LCHK, since the span of the entry read is
// registered before the compare. One item is handled at a time. Reset
// clears the extent count and sets the top to 4096; there is no clearing
// pass.
module page_extent_allocator_core
  import pea_pkg::*;
#(
  parameter int MAX_EXTENTS = 32,
  parameter int PAGE_BYTES  = 4096
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  output logic        in_ready,
  input  req_t        in_data,
  output logic        out_valid,
  input  logic        out_ready,
  output rsp_t        out_data,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [2:0]  paddr,
  input  logic [63:0] pwdata,
  output logic [63:0] prdata,
  output logic        pready
);

  localparam int AW = $clog2(MAX_EXTENTS);
  localparam int CW = $clog2(MAX_EXTENTS + 1);
  localparam logic [CW-1:0] MAXC = CW'(MAX_EXTENTS);
  localparam logic [63:0] PB = 64'(PAGE_BYTES);

  localparam logic [3:0] S_IDLE  = 4'd0;
  localparam logic [3:0] S_RRD   = 4'd1;
  localparam logic [3:0] S_RCHK  = 4'd2;
  localparam logic [3:0] S_RFIN  = 4'd3;
  localparam logic [3:0] S_LRD   = 4'd4;
  localparam logic [3:0] S_LCHK  = 4'd5;
  localparam logic [3:0] S_MRD   = 4'd6;
  localparam logic [3:0] S_MCHK  = 4'd7;
  localparam logic [3:0] S_DRD   = 4'd8;
  localparam logic [3:0] S_DWR   = 4'd9;
  localparam logic [3:0] S_OUT   = 4'd10;
  localparam logic [3:0] S_RFIN2 = 4'd11;
  localparam logic [3:0] S_LSPN  = 4'd12;
  localparam logic [3:0] S_MSPN  = 4'd13;
  localparam logic [3:0] S_MFIN  = 4'd14;

  logic [3:0]    state;
  logic [63:0]   heap_base;
  logic [63:0]   heap_top;
  logic [CW-1:0] count;
  req_t          req;
  rsp_t          rsp;
  logic [CW-1:0] idx;
  logic [AW-1:0] best;
  logic [63:0]   best_start;
  logic [31:0]   best_pages;
  logic          found;
  logic [AW-1:0] hit;
  logic [63:0]   t_start;
  logic [31:0]   t_pages;
  logic [CW-1:0] drop_idx;
  logic [CW-1:0] drop_end;
  logic [63:0]   span_n;
  logic [63:0]   run_end;
  logic [63:0]   mul_a;

  logic          we;
  logic [AW-1:0] waddr;
  logic [95:0]   wdata;
  logic [AW-1:0] raddr;
  logic [95:0]   rdata;
  logic [63:0]   e_start;
  logic [31:0]   e_pages;
  logic [63:0]   e_span;
  logic          cfg_wr;

  pea_ram #(.WIDTH(96), .DEPTH(MAX_EXTENTS)) u_ram (
    .clk(clk), .we(we), .waddr(waddr), .wdata(wdata), .raddr(raddr), .rdata(rdata)
  );

  assign e_start = rdata[95:32];
  assign e_pages = rdata[31:0];
  assign cfg_wr  = psel && penable && pwrite && (paddr == 3'd0);
  assign pready  = 1'b1;
  assign prdata  = (paddr == 3'd0) ? heap_base : 64'd0;
  assign in_ready  = (state == S_IDLE) && !out_valid;
  assign out_data  = rsp;
  assign run_end   = req.address + span_n;

  // Span of the entry just read, and of the merged run, registered to keep each multiply alone.
  always_ff @(posedge clk) begin
    e_span <= 64'(e_pages) * PB;
    mul_a  <= 64'(t_pages) * PB;
  end

  always_comb begin
    raddr = idx[AW-1:0];
    if (state == S_DRD || state == S_DWR) begin
      raddr = AW'(drop_idx + CW'(1));
    end
  end

  always_ff @(posedge clk) begin
    we <= 1'b0;
    if (rst) begin
      state     <= S_IDLE;
      heap_base <= HEAP_BASE_RESET;
      heap_top  <= HEAP_BASE_RESET;
      count     <= '0;
      out_valid <= 1'b0;
    end else begin
      if (out_valid && out_ready) begin
        out_valid <= 1'b0;
      end
      if (cfg_wr) begin
        heap_base <= pwdata;
        heap_top  <= pwdata;
        count     <= '0;
      end
      case (state)
        S_IDLE: begin
          if (in_valid && in_ready) begin
            req    <= in_data;
            span_n <= 64'(in_data.pages) * PB;
            idx    <= '0;
            found  <= 1'b0;
            rsp    <= '{result_address: 64'd0, status: STATUS_DONE};
            state  <= (in_data.op == OP_RESERVE) ? S_RRD : S_LRD;
          end
        end
        S_RRD: begin
          state <= (idx >= count) ? S_RFIN : S_RCHK;
        end
        S_RCHK: begin
          if (e_pages >= req.pages && (!found || best_pages < e_pages)) begin
            best       <= idx[AW-1:0];
            best_start <= e_start;
            best_pages <= e_pages;
            found      <= 1'b1;
            if (e_pages == req.pages) begin
              state <= S_RFIN;
            end else begin
              idx   <= idx + CW'(1);
              state <= S_RRD;
            end
          end else begin
            idx   <= idx + CW'(1);
            state <= S_RRD;
          end
        end
        S_RFIN: begin
          if (found) begin
            rsp.result_address <= best_start;
            if (best_pages > req.pages) begin
              we    <= 1'b1;
              waddr <= best;
              wdata <= {best_start + span_n, best_pages - req.pages};
              state <= S_OUT;
            end else begin
              drop_idx <= CW'(best);
              drop_end <= count;
              state    <= S_RFIN2;
            end
          end else begin
            rsp.result_address <= heap_top;
            heap_top <= heap_top + span_n;
            state    <= S_OUT;
          end
        end
        S_RFIN2, S_MFIN: begin
          state <= S_DRD;
        end
        S_LRD: begin
          if (idx == '0 && run_end == heap_top) begin
            heap_top <= req.address;
            state    <= S_OUT;
          end else if (idx >= count) begin
            if (count >= MAXC) begin
              rsp.status <= STATUS_FULL;
            end else begin
              we    <= 1'b1;
              waddr <= count[AW-1:0];
              wdata <= {req.address, req.pages};
              count <= count + CW'(1);
            end
            state <= S_OUT;
          end else begin
            state <= S_LSPN;
          end
        end
        S_LSPN: begin
          state <= S_LCHK;
        end
        S_LCHK: begin
          if (e_start == run_end) begin
            t_start <= req.address;
            t_pages <= e_pages + req.pages;
            hit     <= idx[AW-1:0];
            we      <= 1'b1;
            waddr   <= idx[AW-1:0];
            wdata   <= {req.address, e_pages + req.pages};
            idx     <= '0;
            state   <= S_MRD;
          end else if (e_start + e_span == req.address) begin
            t_start <= e_start;
            t_pages <= e_pages + req.pages;
            hit     <= idx[AW-1:0];
            we      <= 1'b1;
            waddr   <= idx[AW-1:0];
            wdata   <= {e_start, e_pages + req.pages};
            idx     <= '0;
            state   <= S_MRD;
          end else begin
            idx   <= idx + CW'(1);
            state <= S_LRD;
          end
        end
        S_MRD: begin
          if (idx >= count) begin
            state <= S_OUT;
          end else if (idx[AW-1:0] == hit) begin
            idx <= idx + CW'(1);
          end else begin
            state <= S_MSPN;
          end
        end
        S_MSPN: begin
          state <= S_MCHK;
        end
        S_MCHK: begin
          if (e_start == t_start + mul_a || e_start + e_span == t_start) begin
            we    <= 1'b1;
            waddr <= idx[AW-1:0];
            wdata <= {(e_start == t_start + mul_a) ? t_start : e_start,
                      e_pages + t_pages};
            drop_idx <= CW'(hit);
            drop_end <= count;
            state    <= S_MFIN;
          end else begin
            idx   <= idx + CW'(1);
            state <= S_MRD;
          end
        end
        S_DRD: begin
          if (drop_idx + CW'(1) >= drop_end) begin
            count <= count - CW'(1);
            state <= S_OUT;
          end else begin
            state <= S_DWR;
          end
        end
        S_DWR: begin
          we       <= 1'b1;
          waddr    <= drop_idx[AW-1:0];
          wdata    <= rdata;
          drop_idx <= drop_idx + CW'(1);
          state    <= S_DRD;
        end
        S_OUT: begin
          out_valid <= 1'b1;
          state     <= S_IDLE;
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

endmodule

@@ sv/pea_checker.sv @@
// ----------------------------------------------------------------------------
// Page extent allocator checker
// Port-level properties of the allocator core, bound into the core module.
// ----------------------------------------------------------------------------
module pea_checker
  import pea_pkg::*;
(
  input logic clk,
  input logic rst,
  input logic in_valid,
  input logic in_ready,
  input req_t in_data,
  input logic out_valid,
  input logic out_ready,
  input rsp_t out_data,
  input logic pready
);

  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid && $stable(out_data))
    else $error("Result item changed while stalled.");

  a_no_accept_busy: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> !in_ready)
    else $error("Input taken while a result waits.");

  a_take_busy: assert property (@(posedge clk) disable iff (rst)
    in_valid && in_ready |=> !in_ready)
    else $error("Input ready right after an accepted item.");

  a_no_out_after_rst: assert property (@(posedge clk)
    rst |=> !out_valid)
    else $error("Result item right after reset.");

  a_pready: assert property (@(posedge clk) pready)
    else $error("Configuration port stalled.");

endmodule

bind page_extent_allocator_core pea_checker u_pea_checker (
  .clk(clk), .rst(rst), .in_valid(in_valid), .in_ready(in_ready), .in_data(in_data),
  .out_valid(out_valid), .out_ready(out_ready), .out_data(out_data), .pready(pready)
);

@@ tb/sv/tb_page_extent_allocator_core.sv @@
// ----------------------------------------------------------------------------
// Page extent allocator core testbench
// Drives reserve and release items through the valid/ready ports while a
// built-in model of the worst-fit free list predicts each result. The heap
// base is rewritten between phases, and the sender and the receiver idle at
// varying rates, including one long receiver hold-off.
// ----------------------------------------------------------------------------
module tb_page_extent_allocator_core;
  import pea_pkg::*;

  localparam int          TABLE_DEPTH   = 32;
  localparam logic [63:0] PAGE_SPAN     = 64'd4096;
  localparam logic [2:0]  REG_HEAP_BASE = 3'd0;
  localparam int          STALL_LIMIT   = 20000;

  typedef struct {
    logic [63:0] addr;
    logic [31:0] pages;
  } run_t;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        in_valid = 1'b0;
  logic        in_ready;
  req_t        in_data = '0;
  logic        out_valid;
  logic        out_ready = 1'b0;
  rsp_t        out_data;
  logic        psel = 1'b0;
  logic        penable = 1'b0;
  logic        pwrite = 1'b0;
  logic [2:0]  paddr = '0;
  logic [63:0] pwdata = '0;
  logic [63:0] prdata;
  logic        pready;

  req_t        pending_reqs[$];
  rsp_t        expected_rsps[$];
  run_t        live_runs[$];

  logic [63:0] free_start[TABLE_DEPTH];
  logic [31:0] free_pages[TABLE_DEPTH];
  int          free_count;
  logic [63:0] heap_top;

  int          send_idle_pct = 0;
  int          recv_stall_pct = 0;
  int          hold_cycles = 0;
  int          stall_count = 0;
  bit          failed = 1'b0;

  page_extent_allocator_core DUT (
    .clk(clk), .rst(rst),
    .in_valid(in_valid), .in_ready(in_ready), .in_data(in_data),
    .out_valid(out_valid), .out_ready(out_ready), .out_data(out_data),
    .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
    .pwdata(pwdata), .prdata(prdata), .pready(pready)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  function automatic void drop_extent(int idx);
    for (int k = idx; k + 1 < free_count; k++) begin
      free_start[k] = free_start[k + 1];
      free_pages[k] = free_pages[k + 1];
    end
    free_count--;
  endfunction

  function automatic logic [63:0] predict_reserve(logic [31:0] n);
    int          best;
    bit          found;
    logic [63:0] addr;
    best = 0;
    found = 1'b0;
    for (int i = 0; i < free_count; i++) begin
      if (free_pages[i] >= n && (!found || free_pages[best] < free_pages[i])) begin
        best = i;
        found = 1'b1;
        if (free_pages[i] == n) break;
      end
    end
    if (found) begin
      addr = free_start[best];
      if (free_pages[best] > n) begin
        free_start[best] += PAGE_SPAN * n;
        free_pages[best] -= n;
      end else begin
        drop_extent(best);
      end
      return addr;
    end
    addr = heap_top;
    heap_top += PAGE_SPAN * n;
    return addr;
  endfunction

  function automatic logic predict_release(logic [63:0] a, logic [31:0] n);
    logic [63:0] run_end;
    logic [63:0] t_start;
    logic [63:0] t_end;
    int          hit;
    bit          merged;
    run_end = a + PAGE_SPAN * n;
    hit = 0;
    merged = 1'b0;
    if (run_end == heap_top) begin
      heap_top = a;
      return STATUS_DONE;
    end
    for (int i = 0; i < free_count; i++) begin
      if (free_start[i] == run_end) begin
        free_start[i] = a;
        free_pages[i] += n;
        merged = 1'b1;
      end else if (free_start[i] + PAGE_SPAN * free_pages[i] == a) begin
        free_pages[i] += n;
        merged = 1'b1;
      end
      if (merged) begin
        hit = i;
        break;
      end
    end
    if (!merged) begin
      if (free_count >= TABLE_DEPTH) return STATUS_FULL;
      free_start[free_count] = a;
      free_pages[free_count] = n;
      free_count++;
      return STATUS_DONE;
    end
    t_start = free_start[hit];
    t_end = t_start + PAGE_SPAN * free_pages[hit];
    for (int j = 0; j < free_count; j++) begin
      if (j == hit) continue;
      if (free_start[j] == t_end) begin
        free_start[j] = t_start;
        free_pages[j] += free_pages[hit];
        drop_extent(hit);
        break;
      end
      if (free_start[j] + PAGE_SPAN * free_pages[j] == t_start) begin
        free_pages[j] += free_pages[hit];
        drop_extent(hit);
        break;
      end
    end
    return STATUS_DONE;
  endfunction

  // Items are predicted in order as they are queued, so the allocator state
  // seen here matches the state the block will have when it takes the item.
  function automatic void queue_request(logic op, logic [63:0] a, logic [31:0] n);
    req_t req;
    rsp_t rsp;
    req.op = op;
    req.address = a;
    req.pages = n;
    if (op == OP_RESERVE) begin
      rsp.result_address = predict_reserve(n);
      rsp.status = STATUS_DONE;
      if (n != 0) live_runs.push_back('{rsp.result_address, n});
    end else begin
      rsp.result_address = '0;
      rsp.status = predict_release(a, n);
    end
    pending_reqs.push_back(req);
    expected_rsps.push_back(rsp);
  endfunction

  function automatic void queue_random_request();
    int   pick;
    int   roll;
    int   k;
    run_t run;
    roll = $urandom_range(0, 99);
    if (roll < 5) begin
      queue_request(OP_RELEASE, {$urandom, $urandom}, $urandom);
    end else if (roll < 7) begin
      queue_request(OP_RESERVE, {$urandom, $urandom}, $urandom);
    end else if (roll < 50 || live_runs.size() == 0) begin
      queue_request(OP_RESERVE, {$urandom, $urandom}, $urandom_range(0, 12));
    end else begin
      pick = $urandom_range(0, live_runs.size() - 1);
      run = live_runs[pick];
      live_runs.delete(pick);
      if (run.pages > 1 && $urandom_range(0, 3) == 0) begin
        k = $urandom_range(1, run.pages - 1);
        queue_request(OP_RELEASE, run.addr, k);
        live_runs.push_back('{run.addr + PAGE_SPAN * k, run.pages - k});
      end else begin
        queue_request(OP_RELEASE, run.addr, run.pages);
      end
    end
  endfunction

  task automatic wait_idle();
    while (pending_reqs.size() != 0 || in_valid || expected_rsps.size() != 0)
      @(posedge clk);
    repeat (10) @(posedge clk);
  endtask

  task automatic write_heap_base(logic [63:0] value);
    @(posedge clk);
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= 1'b1;
    paddr <= REG_HEAP_BASE;
    pwdata <= value;
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    psel <= 1'b0;
    penable <= 1'b0;
    pwrite <= 1'b0;
    heap_top = value;
    free_count = 0;
    live_runs.delete();
  endtask

  always @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else if (!in_valid || in_ready) begin
      if (pending_reqs.size() != 0 && $urandom_range(0, 99) >= send_idle_pct) begin
        in_valid <= 1'b1;
        in_data <= pending_reqs.pop_front();
      end else begin
        in_valid <= 1'b0;
      end
    end
  end

  always @(posedge clk) begin
    if (rst) begin
      out_ready <= 1'b0;
    end else if (hold_cycles > 0) begin
      out_ready <= 1'b0;
      hold_cycles <= hold_cycles - 1;
    end else begin
      out_ready <= ($urandom_range(0, 99) >= recv_stall_pct);
    end
  end

  always @(posedge clk) begin
    rsp_t exp_rsp;
    if (!rst && out_valid && out_ready) begin
      if (expected_rsps.size() == 0) begin
        $error("unexpected item: result_address %h status %b",
               out_data.result_address, out_data.status);
        failed = 1'b1;
      end else begin
        exp_rsp = expected_rsps.pop_front();
        if (out_data.result_address !== exp_rsp.result_address) begin
          $error("result_address: expected %h, actual %h",
                 exp_rsp.result_address, out_data.result_address);
          failed = 1'b1;
        end
        if (out_data.status !== exp_rsp.status) begin
          $error("status: expected %b, actual %b", exp_rsp.status, out_data.status);
          failed = 1'b1;
        end
      end
    end
  end

  always @(posedge clk) begin
    if (rst || (in_valid && in_ready) || (out_valid && out_ready)) begin
      stall_count <= 0;
    end else if (stall_count >= STALL_LIMIT) begin
      $display("** page_extent_allocator_core: FAILED **");
      $finish;
    end else begin
      stall_count <= stall_count + 1;
    end
  end

  initial begin
    logic [63:0] bases[5];
    int          idle_set[4];
    int          stall_set[4];
    bases = '{64'd4096, 64'd1, 64'hFFFF_FFFF_FFFF_FFFF, 64'hFFFF_FFFF_FFFF_0000,
              {$urandom, $urandom}};
    idle_set = '{0, 78, 0, 29};
    stall_set = '{0, 0, 78, 29};
    heap_top = HEAP_BASE_RESET;
    free_count = 0;
    repeat (9) @(posedge clk);
    rst <= 1'b0;

    // Directed: empty-table zero reserve, exact fit, zero-page reserve on a
    // table, merges, a release ending at the top, extremes and address zero.
    queue_request(OP_RESERVE, '0, 32'd0);
    queue_request(OP_RESERVE, '0, 32'd1);
    queue_request(OP_RESERVE, '0, 32'd4);
    queue_request(OP_RESERVE, '0, 32'd2);
    queue_request(OP_RESERVE, '0, 32'd3);
    queue_request(OP_RELEASE, 64'd4096, 32'd1);
    queue_request(OP_RESERVE, '0, 32'd0);
    queue_request(OP_RELEASE, 64'd4096 * 6, 32'd2);
    queue_request(OP_RELEASE, 64'd4096 * 2, 32'd4);
    queue_request(OP_RESERVE, '0, 32'd7);
    queue_request(OP_RELEASE, 64'd4096 * 8, 32'd3);
    queue_request(OP_RESERVE, '0, 32'd2);
    queue_request(OP_RELEASE, 64'd0, 32'd5);
    queue_request(OP_RESERVE, '0, 32'd5);
    queue_request(OP_RELEASE, 64'hFFFF_FFFF_FFFF_FFFF, 32'hFFFF_FFFF);
    queue_request(OP_RESERVE, 64'hFFFF_FFFF_FFFF_FFFF, 32'hFFFF_FFFF);
    queue_request(OP_RESERVE, '0, 32'd1);
    queue_request(OP_RELEASE, 64'hAAAA_5555_AAAA_5555, 32'h5555_AAAA);
    queue_request(OP_RESERVE, '0, 32'd0);
    wait_idle();

    for (int ph = 0; ph < 5; ph++) begin
      write_heap_base(bases[ph]);
      send_idle_pct = idle_set[ph % 4];
      recv_stall_pct = stall_set[ph % 4];
      if (ph == 1) hold_cycles = 400;
      // Scattered single-page holes overflow the free table.
      for (int i = 0; i < 70; i++) queue_request(OP_RESERVE, '0, 32'd1);
      for (int i = 0; i < 70; i += 2)
        queue_request(OP_RELEASE, bases[ph] + PAGE_SPAN * i, 32'd1);
      live_runs.delete();
      for (int i = 1; i < 70; i += 2)
        live_runs.push_back('{bases[ph] + PAGE_SPAN * i, 32'd1});
      for (int i = 0; i < 240; i++) queue_random_request();
      wait_idle();
    end

    if (!failed) begin
      $display("** page_extent_allocator_core: PASSED **");
    end else begin
      $display("** page_extent_allocator_core: FAILED **");
    end
    $finish;
  end

endmodule
